FILE: sv/bsu_pkg.sv
// Shared types and constants of the bounding sphere union accumulator.
`default_nettype none
package bsu_pkg;
	localparam int FRAC_BITS = 12;
	localparam int RAD_W = 31;
	localparam int CNT_W = 16;
	localparam int D_W = 34;
	localparam int PROD_W = 68;
	localparam int HALF_W = 17;
	localparam int QUOT_W = 35;
	localparam int SQ_STEPS = 34;
	localparam int DIV_STEPS = 35;
	localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam longint MIN_RESET_L = (64'd1 << FRAC_BITS) / 1000;
	localparam longint MAX_FULL_L = 64'd100000 << FRAC_BITS;
	localparam logic [RAD_W-1:0] MIN_RESET = RAD_W'(MIN_RESET_L);
	localparam logic [RAD_W-1:0] MAX_RESET =
		(MAX_FULL_L > 64'h7FFFFFFF) ? RAD_MAX : RAD_W'(MAX_FULL_L);
	localparam logic CFG_MIN_RADIUS = 1'b0;
	localparam logic CFG_MAX_RADIUS = 1'b1;
	localparam logic KIND_CLEAR = 1'b0;

	typedef logic [1:0] coord_t;

	typedef struct packed {
		logic   latch;
		logic   clear;
		logic   load_new;
		logic   bump;
		logic   mul_en;
		logic   mul_first;
		logic   mul_hi;
		logic   mul_use_k;
		coord_t coord;
		logic   sqrt_init;
		logic   sqrt_step;
		logic   merge;
		logic   div_init;
		logic   div_step;
		logic   apply;
		logic   out_load;
	} bsu_cmd_t;

	typedef struct packed {
		logic is_add;
		logic usable;
		logic first;
		logic contained;
		logic replace;
	} bsu_stat_t;
endpackage
`default_nettype wire

FILE: sv/bsu_if.sv
// Input and result channel interfaces of the bounding sphere union accumulator.
`default_nettype none
interface bsu_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic signed [31:0] center_z;
	logic signed [31:0] radius;
	modport source(output valid, kind, center_x, center_y, center_z, radius, input ready);
	modport sink(input valid, kind, center_x, center_y, center_z, radius, output ready);
endinterface

interface bsu_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] union_x;
	logic signed [31:0] union_y;
	logic signed [31:0] union_z;
	logic [30:0]        union_radius;
	logic               accepted;
	logic [15:0]        spheres_seen;
	modport source(output valid, union_x, union_y, union_z, union_radius, accepted,
		spheres_seen, input ready);
	modport sink(input valid, union_x, union_y, union_z, union_radius, accepted,
		spheres_seen, output ready);
endinterface
`default_nettype wire

FILE: sv/bsu_ctrl.sv
// Sequencing state machine of the bounding sphere union accumulator.
`default_nettype none
module bsu_ctrl
	import bsu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire bsu_stat_t stat,
	output bsu_cmd_t  cmd
);
	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_CHECK  = 9'b000000010,
		ST_SQ     = 9'b000000100,
		ST_SQRT   = 9'b000001000,
		ST_DECIDE = 9'b000010000,
		ST_MUL    = 9'b000100000,
		ST_DIV    = 9'b001000000,
		ST_APPLY  = 9'b010000000,
		ST_OUT    = 9'b100000000
	} state_t;

	state_t     state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	coord_t     coord_q, coord_d;
	logic       out_valid_q, out_valid_d;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		coord_d = coord_q;
		out_valid_d = out_valid_q;
		cmd = '0;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cnt_d = '0;
				coord_d = '0;
				if (!stat.is_add) begin
					cmd.clear = 1'b1;
					state_d = ST_OUT;
				end else if (!stat.usable) begin
					state_d = ST_OUT;
				end else if (stat.first) begin
					cmd.load_new = 1'b1;
					cmd.bump = 1'b1;
					state_d = ST_OUT;
				end else begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.mul_en = 1'b1;
				cmd.mul_first = (cnt_q == 6'd0);
				cmd.mul_hi = cnt_q[0];
				cmd.coord = cnt_q[2:1];
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd5) begin
					cnt_d = '0;
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_init = (cnt_q == 6'd0);
				cmd.sqrt_step = (cnt_q != 6'd0);
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(SQ_STEPS)) begin
					cnt_d = '0;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.bump = 1'b1;
				if (stat.contained) begin
					state_d = ST_OUT;
				end else if (stat.replace) begin
					cmd.load_new = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.merge = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_use_k = 1'b1;
				cmd.mul_first = (cnt_q == 6'd0);
				cmd.mul_hi = cnt_q[0];
				cmd.coord = coord_q;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd1) begin
					cnt_d = '0;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_init = (cnt_q == 6'd0);
				cmd.div_step = (cnt_q != 6'd0);
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS)) begin
					cnt_d = '0;
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				cmd.coord = coord_q;
				if (coord_q == 2'd2) begin
					state_d = ST_OUT;
				end else begin
					coord_d = coord_q + 2'd1;
					state_d = ST_MUL;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			coord_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			coord_q <= coord_d;
			out_valid_q <= out_valid_d;
		end
	end

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_CHECK)
		else $error("accepted item did not enter check");
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not presented after load");
	a_sqrt_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQRT && cnt_q == 6'(SQ_STEPS) |=> state_q == ST_DECIDE)
		else $error("root did not finish on time");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready)
		else $error("ready while busy");
endmodule
`default_nettype wire

FILE: sv/bsu_dp.sv
// Datapath of the bounding sphere union accumulator: union state, multiplier, root, divider.
`default_nettype none
module bsu_dp
	import bsu_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [RAD_W-1:0]   cfg_data,
	input  wire logic               kind,
	input  wire logic signed [31:0] center_x,
	input  wire logic signed [31:0] center_y,
	input  wire logic signed [31:0] center_z,
	input  wire logic signed [31:0] radius,
	input  wire bsu_cmd_t           cmd,
	output bsu_stat_t               stat,
	output logic signed [31:0]      union_x,
	output logic signed [31:0]      union_y,
	output logic signed [31:0]      union_z,
	output logic [RAD_W-1:0]        union_radius,
	output logic                    accepted,
	output logic [CNT_W-1:0]        spheres_seen
);
	logic [RAD_W-1:0]   min_q, max_q;
	logic               kind_q;
	logic signed [31:0] in_x_q, in_y_q, in_z_q, in_r_q;
	logic signed [31:0] acc_x_q, acc_y_q, acc_z_q;
	logic [RAD_W-1:0]   acc_r_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               acc_flag_q;
	logic [PROD_W-1:0]  mul_q;
	logic [PROD_W-1:0]  rad_q;
	logic [36:0]        rem_q;
	logic [D_W-1:0]     root_q;
	logic [D_W-1:0]     k_q;
	logic [D_W-1:0]     drem_q;
	logic [QUOT_W-1:0]  quot_q;

	logic signed [31:0] sel_in, sel_acc;
	logic signed [32:0] diff;
	logic [32:0]        mag;
	logic [D_W-1:0]     opb;
	logic [HALF_W-1:0]  bhalf;
	logic [49:0]        prod;
	logic [PROD_W-1:0]  term;
	logic [36:0]        sq_t, sq_trial;
	logic [D_W:0]       dv_t;
	logic [D_W:0]       sum_d2, sum_d1;
	logic [D_W+1:0]     sum_all;
	logic [D_W:0]       nr;
	logic [31:0]        shifted;

	always_comb begin
		case (cmd.coord)
			2'd0: begin sel_in = in_x_q; sel_acc = acc_x_q; end
			2'd1: begin sel_in = in_y_q; sel_acc = acc_y_q; end
			default: begin sel_in = in_z_q; sel_acc = acc_z_q; end
		endcase
	end

	assign diff = 33'(sel_in) - 33'(sel_acc);
	assign mag = diff[32] ? 33'(-diff) : 33'(diff);
	assign opb = cmd.mul_use_k ? k_q : {1'b0, mag};
	assign bhalf = cmd.mul_hi ? opb[D_W-1:HALF_W] : opb[HALF_W-1:0];
	assign prod = 50'(mag) * 50'(bhalf);
	assign term = cmd.mul_hi ? {1'b0, prod, {HALF_W{1'b0}}} : PROD_W'(prod);

	assign sq_t = {rem_q[34:0], rad_q[PROD_W-1:PROD_W-2]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign dv_t = {drem_q, quot_q[QUOT_W-1]};

	assign sum_d2 = (D_W+1)'(root_q) + (D_W+1)'(in_r_q[RAD_W-1:0]);
	assign sum_d1 = (D_W+1)'(root_q) + (D_W+1)'(acc_r_q);
	assign sum_all = (D_W+2)'(sum_d1) + (D_W+2)'(in_r_q[RAD_W-1:0]);
	assign nr = sum_all[D_W+1:1];
	assign shifted = diff[32] ? 32'(sel_acc) - quot_q[31:0] : 32'(sel_acc) + quot_q[31:0];

	assign stat.is_add = (kind_q != KIND_CLEAR);
	assign stat.usable = (in_r_q > $signed({1'b0, min_q})) && (in_r_q <= $signed({1'b0, max_q}));
	assign stat.first = (cnt_q == '0);
	assign stat.contained = (sum_d2 <= (D_W+1)'(acc_r_q));
	assign stat.replace = (sum_d1 <= (D_W+1)'(in_r_q[RAD_W-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_RESET;
			max_q <= MAX_RESET;
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
			acc_r_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MIN_RADIUS) begin
					min_q <= cfg_data;
				end else begin
					max_q <= cfg_data;
				end
			end
			if (cmd.clear) begin
				acc_x_q <= '0;
				acc_y_q <= '0;
				acc_z_q <= '0;
				acc_r_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.load_new) begin
				acc_x_q <= in_x_q;
				acc_y_q <= in_y_q;
				acc_z_q <= in_z_q;
				acc_r_q <= in_r_q[RAD_W-1:0];
			end
			if (cmd.bump && cnt_q != CNT_MAX) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.merge) begin
				acc_r_q <= (nr > (D_W+1)'(RAD_MAX)) ? RAD_MAX : nr[RAD_W-1:0];
			end
			if (cmd.apply) begin
				case (cmd.coord)
					2'd0: acc_x_q <= shifted;
					2'd1: acc_y_q <= shifted;
					default: acc_z_q <= shifted;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind;
			in_x_q <= center_x;
			in_y_q <= center_y;
			in_z_q <= center_z;
			in_r_q <= radius;
		end
		if (cmd.latch) begin
			acc_flag_q <= 1'b0;
		end else if (cmd.bump) begin
			acc_flag_q <= 1'b1;
		end
		if (cmd.mul_en) begin
			mul_q <= cmd.mul_first ? term : mul_q + term;
		end
		if (cmd.sqrt_init) begin
			rad_q <= mul_q;
			rem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[PROD_W-3:0], 2'b00};
			if (sq_t >= sq_trial) begin
				rem_q <= sq_t - sq_trial;
				root_q <= {root_q[D_W-2:0], 1'b1};
			end else begin
				rem_q <= sq_t;
				root_q <= {root_q[D_W-2:0], 1'b0};
			end
		end
		if (cmd.merge) begin
			k_q <= nr[D_W-1:0] - D_W'(acc_r_q);
		end
		if (cmd.div_init) begin
			drem_q <= mul_q[PROD_W-1:QUOT_W] == '0 ? '0 : D_W'(mul_q[PROD_W-1:QUOT_W]);
			quot_q <= mul_q[QUOT_W-1:0];
		end else if (cmd.div_step) begin
			if (dv_t >= {1'b0, root_q}) begin
				drem_q <= D_W'(dv_t - {1'b0, root_q});
				quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
			end else begin
				drem_q <= dv_t[D_W-1:0];
				quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			union_x <= acc_x_q;
			union_y <= acc_y_q;
			union_z <= acc_z_q;
			union_radius <= acc_r_q;
			accepted <= acc_flag_q;
			spheres_seen <= cnt_q;
		end
	end
endmodule
`default_nettype wire

FILE: sv/bounding_sphere_union_accumulator.sv
// Top level of the bounding sphere union accumulator.
// One item at a time. A clear, an unusable sphere or the first usable sphere
// goes from the check state to output; a contained or replacing sphere adds
// six half-width products for the squared distance, a 34-step bit-serial
// square root and a decision state; a true merge adds the shared 33x17
// multiplier and the 35-step restoring divider, run once per axis. The result
// sits in an output register, so the next item is taken while the previous
// result waits. The user must write min_radius and max_radius through cfg_we,
// cfg_index and cfg_data only while idle; the block does not enforce this.
`default_nettype none
module bounding_sphere_union_accumulator
	import bsu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [RAD_W-1:0] cfg_data,
	bsu_in_if.sink                in_ch,
	bsu_out_if.source             out_ch
);
	bsu_cmd_t  cmd;
	bsu_stat_t stat;

	bsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bsu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (in_ch.kind),
		.center_x     (in_ch.center_x),
		.center_y     (in_ch.center_y),
		.center_z     (in_ch.center_z),
		.radius       (in_ch.radius),
		.cmd          (cmd),
		.stat         (stat),
		.union_x      (out_ch.union_x),
		.union_y      (out_ch.union_y),
		.union_z      (out_ch.union_z),
		.union_radius (out_ch.union_radius),
		.accepted     (out_ch.accepted),
		.spheres_seen (out_ch.spheres_seen)
	);
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench of the bounding sphere union accumulator.
`default_nettype none
module tb_top
	import bsu_pkg::*;
();

	typedef struct packed {
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
		logic [30:0]        ur;
		logic               acc;
		logic [15:0]        seen;
	} union_t;

	typedef struct {
		logic               kind;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic signed [31:0] r;
		bit                 typed;
		union_t             want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_MIN_RADIUS;
	logic [RAD_W-1:0] cfg_data = '0;

	bsu_in_if in_ch();
	bsu_out_if out_ch();

	bounding_sphere_union_accumulator DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic signed [31:0] sph_x, sph_y, sph_z;
	logic [31:0] sph_r;
	logic [15:0] sph_n;
	logic [30:0] lim_lo, lim_hi;
	union_t pending[$];
	int errors = 0;
	int send_idle = 0, recv_idle = 0;
	int hold_cycles = 0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	function automatic logic [35:0] isqrt(input logic [69:0] n);
		logic [36:0] lo, hi, mid;
		lo = 0;
		hi = 37'd1 << 36;
		while (hi - lo > 1) begin
			mid = lo + ((hi - lo) >> 1);
			if ({37'd0, mid} * {37'd0, mid} <= {4'd0, n})
				lo = mid;
			else
				hi = mid;
		end
		return lo[35:0];
	endfunction

	function automatic logic signed [31:0] shift_axis(input logic signed [31:0] c,
			input logic signed [33:0] diff, input logic [35:0] k, input logic [35:0] d);
		logic [33:0] m;
		logic [69:0] p;
		logic [69:0] q;
		logic signed [71:0] s;
		m = diff < 0 ? -diff : diff;
		p = {36'd0, m} * {34'd0, k};
		q = p / {34'd0, d};
		s = diff < 0 ? 72'(signed'(c)) - signed'({2'b0, q}) : 72'(signed'(c)) + signed'({2'b0, q});
		return s[31:0];
	endfunction

	function automatic union_t merge_sphere(input logic kind, input logic signed [31:0] cx,
			input logic signed [31:0] cy, input logic signed [31:0] cz,
			input logic signed [31:0] r);
		union_t u;
		logic signed [33:0] dx, dy, dz;
		logic [69:0] s;
		logic [35:0] d, r1, r2, nr;
		u.acc = 1'b0;
		if (kind == KIND_CLEAR) begin
			sph_x = 0; sph_y = 0; sph_z = 0; sph_r = 0; sph_n = 0;
		end else if (r > signed'({1'b0, lim_lo}) && r <= signed'({1'b0, lim_hi})) begin
			u.acc = 1'b1;
			if (sph_n == 0) begin
				sph_x = cx; sph_y = cy; sph_z = cz; sph_r = r;
			end else begin
				dx = 34'(cx) - 34'(sph_x);
				dy = 34'(cy) - 34'(sph_y);
				dz = 34'(cz) - 34'(sph_z);
				s = 70'(dx) * 70'(dx) + 70'(dy) * 70'(dy) + 70'(dz) * 70'(dz);
				d = isqrt(s);
				r1 = 36'(sph_r);
				r2 = 36'(r);
				if (d + r2 <= r1) begin
				end else if (d + r1 <= r2) begin
					sph_x = cx; sph_y = cy; sph_z = cz; sph_r = r;
				end else begin
					nr = (d + r1 + r2) >> 1;
					if (d > 0) begin
						sph_x = shift_axis(sph_x, dx, nr - r1, d);
						sph_y = shift_axis(sph_y, dy, nr - r1, d);
						sph_z = shift_axis(sph_z, dz, nr - r1, d);
					end
					sph_r = nr > 36'h7FFFFFFF ? 32'h7FFFFFFF : nr[31:0];
				end
			end
			if (sph_n != CNT_MAX)
				sph_n++;
		end
		u.ux = sph_x; u.uy = sph_y; u.uz = sph_z; u.ur = sph_r[30:0]; u.seen = sph_n;
		return u;
	endfunction

	task automatic write_limit(input logic idx, input logic [RAD_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MIN_RADIUS)
			lim_lo = val;
		else
			lim_hi = val;
		@(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic send(input row_t it);
		union_t u;
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= it.kind;
		in_ch.center_x <= it.cx;
		in_ch.center_y <= it.cy;
		in_ch.center_z <= it.cz;
		in_ch.radius <= it.r;
		do @(posedge clk); while (!in_ch.ready);
		u = merge_sphere(it.kind, it.cx, it.cy, it.cz, it.r);
		if (it.typed && u != it.want)
			report("directed row", 64'(u), 64'(it.want));
		pending.push_back(u);
	endtask

	function automatic logic signed [31:0] rnd_coord(input int spread);
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			default: return signed'($urandom_range(2 * spread)) - spread;
		endcase
	endfunction

	function automatic row_t rnd_item();
		row_t it;
		it.typed = 1'b0;
		it.want = '0;
		it.kind = $urandom_range(19) != 0;
		it.cx = rnd_coord(1 << 20);
		it.cy = rnd_coord(1 << 20);
		it.cz = rnd_coord(1 << 20);
		case ($urandom_range(9))
			0: it.r = $urandom;
			1: it.r = -$urandom_range(100);
			2: it.r = lim_lo + $urandom_range(1);
			3: it.r = lim_hi + $urandom_range(1);
			default: it.r = $urandom_range(1 << 21, 1);
		endcase
		return it;
	endfunction

	always @(posedge clk) begin
		union_t g, w;
		if (out_ch.valid && out_ch.ready) begin
			g = '{out_ch.union_x, out_ch.union_y, out_ch.union_z, out_ch.union_radius,
				out_ch.accepted, out_ch.spheres_seen};
			if (pending.size() == 0) begin
				report("unexpected transfer", 64'(g.ur), 0);
			end else begin
				w = pending.pop_front();
				if (g.ux != w.ux) report("union_x", 64'(g.ux), 64'(w.ux));
				if (g.uy != w.uy) report("union_y", 64'(g.uy), 64'(w.uy));
				if (g.uz != w.uz) report("union_z", 64'(g.uz), 64'(w.uz));
				if (g.ur != w.ur) report("union_radius", 64'(g.ur), 64'(w.ur));
				if (g.acc != w.acc) report("accepted", 64'(g.acc), 64'(w.acc));
				if (g.seen != w.seen) report("spheres_seen", 64'(g.seen), 64'(w.seen));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
		end
	end

	initial begin
		#20_000_000;
		$display("[bounding_sphere_union_accumulator] ERROR");
		$finish;
	end

	initial begin
		row_t rows[$];
		row_t it;
		int phase;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_CLEAR;
		in_ch.center_x = 0;
		in_ch.center_y = 0;
		in_ch.center_z = 0;
		in_ch.radius = 0;
		out_ch.ready = 1'b0;
		lim_lo = MIN_RESET;
		lim_hi = MAX_RESET;
		sph_x = 0; sph_y = 0; sph_z = 0; sph_r = 0; sph_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{1'b1, 0, 0, 0, 4, 1'b1, '{0, 0, 0, 0, 1'b0, 0}},
			'{1'b1, 10, 20, 30, 5, 1'b1, '{10, 20, 30, 5, 1'b1, 1}},
			'{KIND_CLEAR, 7, 7, 7, 7, 1'b1, '{0, 0, 0, 0, 1'b0, 0}},
			'{1'b1, 0, 0, 0, -1, 1'b1, '{0, 0, 0, 0, 1'b0, 0}},
			'{1'b1, 0, 0, 0, 32'h8000_0000, 1'b1, '{0, 0, 0, 0, 1'b0, 0}},
			'{1'b1, 0, 0, 0, 409600001, 1'b1, '{0, 0, 0, 0, 1'b0, 0}},
			'{1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 409600000, 1'b1,
				'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 409600000, 1'b1, 1}},
			'{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 409600000, 1'b0, '0},
			'{1'b1, 0, 0, 0, 100, 1'b0, '0},
			'{KIND_CLEAR, 0, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 1'b0, 0}},
			'{1'b1, 0, 0, 0, 1000, 1'b1, '{0, 0, 0, 1000, 1'b1, 1}},
			'{1'b1, 10, 0, 0, 100, 1'b1, '{0, 0, 0, 1000, 1'b1, 2}},
			'{1'b1, 0, 0, 10, 5000, 1'b1, '{0, 0, 10, 5000, 1'b1, 3}},
			'{1'b1, 9000, -3000, 10, 2000, 1'b0, '0},
			'{1'b1, 0, 0, 10, 2000, 1'b0, '0},
			'{1'b1, -400000, 123456, -777, 300, 1'b0, '0},
			'{KIND_CLEAR, 0, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 1'b0, 0}}
		};
		foreach (rows[i])
			send(rows[i]);
		drain();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_limit(CFG_MIN_RADIUS, 0); write_limit(CFG_MAX_RADIUS, RAD_MAX); end
				1: begin write_limit(CFG_MIN_RADIUS, 1000); write_limit(CFG_MAX_RADIUS, 1000); end
				2: begin write_limit(CFG_MIN_RADIUS, RAD_MAX); write_limit(CFG_MAX_RADIUS, 0); end
				3: begin write_limit(CFG_MIN_RADIUS, 16); write_limit(CFG_MAX_RADIUS, 1 << 20); end
				default: begin
					write_limit(CFG_MIN_RADIUS, MIN_RESET);
					write_limit(CFG_MAX_RADIUS, MAX_RESET);
				end
			endcase
			send_idle = phase == 3 ? 12 : phase == 4 ? 73 : 0;
			recv_idle = phase == 3 ? 73 : phase == 4 ? 12 : 0;
			if (phase == 5)
				hold_cycles <= 3000;
			repeat (phase < 3 ? 30 : 220) begin
				it = rnd_item();
				send(it);
				if ($urandom_range(99) == 0) begin
					in_ch.valid <= 1'b0;
					while (pending.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end
		if (errors == 0)
			$display("[bounding_sphere_union_accumulator] OK");
		else
			$display("[bounding_sphere_union_accumulator] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

FILE: bounding_sphere_union_accumulator.f
sv/bsu_pkg.sv
sv/bsu_if.sv
sv/bsu_ctrl.sv
sv/bsu_dp.sv
sv/bounding_sphere_union_accumulator.sv
dv/tb_top.sv
